@@ rtl/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and defaults for the double-ended queue block: command and
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_DUMP_FWD   = 2'd2,
    CMD_DUMP_REV   = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    STS_PUSH_OK    = 2'd0,
    STS_PUSH_FULL  = 2'd1,
    STS_DUMP_ELEM  = 2'd2,
    STS_DUMP_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic latch;
    logic push;
    logic empty_result;
    logic walk_init;
    logic emit_elem;
  } dp_cmd_t;

  typedef struct packed {
    logic is_dump;
    logic empty;
    logic walk_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/dq_datapath.sv @@
// ----------------------------------------------------------------------------
// dq_datapath
// Ring key store with front index and element count, dump walker with a
// registered read port, and the result output register.
// ----------------------------------------------------------------------------
module dq_datapath #(
  parameter int CAPACITY  = dq_pkg::CAPACITY,
  parameter int KEY_WIDTH = dq_pkg::KEY_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [1:0]                  in_command,
  input  logic signed [KEY_WIDTH-1:0] in_key,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic signed [KEY_WIDTH-1:0] out_key_out,
  output logic                        out_last,
  input  dq_pkg::dp_cmd_t             cmd,
  output dq_pkg::dp_stat_t            stat
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam logic [SUM_W-1:0] CAP_S    = SUM_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

  function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
    wrap = (s >= CAP_S) ? IDX_W'(s - CAP_S) : IDX_W'(s);
  endfunction

  function automatic logic [IDX_W-1:0] inc(input logic [IDX_W-1:0] p);
    inc = (p == IDX_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] dec(input logic [IDX_W-1:0] p);
    dec = (p == '0) ? IDX_LAST : p - 1'b1;
  endfunction

  logic [KEY_WIDTH-1:0] mem [CAPACITY];

  dq_pkg::command_t     cmd_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [IDX_W-1:0]     front_r, front_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     remain_r, remain_nxt;
  logic [KEY_WIDTH-1:0] rd_data_r;
  logic                 out_valid_r, out_valid_nxt;
  dq_pkg::status_t      out_status_r, out_status_nxt;
  logic [KEY_WIDTH-1:0] out_key_r, out_key_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 wr_en, rd_en;
  logic [IDX_W-1:0]     wr_addr, rd_addr;
  logic [IDX_W-1:0]     back_pos, tail_pos;
  logic                 empty, full, fwd, walk_last, out_free;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CAP_C);
  assign fwd       = (cmd_r == dq_pkg::CMD_DUMP_FWD);
  assign walk_last = (remain_r == CNT_W'(1));
  assign out_free  = !out_valid_r || out_ready;
  assign back_pos  = wrap(SUM_W'(front_r) + SUM_W'(count_r) - 1'b1);
  assign tail_pos  = wrap(SUM_W'(front_r) + SUM_W'(count_r));

  assign stat.is_dump   = (cmd_r == dq_pkg::CMD_DUMP_FWD) || (cmd_r == dq_pkg::CMD_DUMP_REV);
  assign stat.empty     = empty;
  assign stat.walk_last = walk_last;
  assign stat.out_free  = out_free;

  always_comb begin
    front_nxt      = front_r;
    count_nxt      = count_r;
    rd_ptr_nxt     = rd_ptr_r;
    remain_nxt     = remain_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = front_r;
    rd_en          = 1'b0;
    rd_addr        = rd_ptr_r;

    if (cmd.push) begin
      out_valid_nxt = 1'b1;
      out_key_nxt   = '0;
      out_last_nxt  = 1'b1;
      if (full) begin
        out_status_nxt = dq_pkg::STS_PUSH_FULL;
      end else begin
        out_status_nxt = dq_pkg::STS_PUSH_OK;
        wr_en          = 1'b1;
        count_nxt      = count_r + 1'b1;
        if (empty) begin
          wr_addr = front_r;
        end else if (cmd_r == dq_pkg::CMD_PUSH_FRONT) begin
          front_nxt = dec(front_r);
          wr_addr   = dec(front_r);
        end else begin
          wr_addr = tail_pos;
        end
      end
    end

    if (cmd.empty_result) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = dq_pkg::STS_DUMP_EMPTY;
      out_key_nxt    = '0;
      out_last_nxt   = 1'b1;
    end

    if (cmd.walk_init) begin
      rd_en      = 1'b1;
      rd_addr    = fwd ? front_r : back_pos;
      remain_nxt = count_r;
    end

    if (cmd.emit_elem) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = dq_pkg::STS_DUMP_ELEM;
      out_key_nxt    = rd_data_r;
      out_last_nxt   = walk_last;
      remain_nxt     = remain_r - 1'b1;
      if (!walk_last) begin
        rd_en   = 1'b1;
        rd_addr = fwd ? inc(rd_ptr_r) : dec(rd_ptr_r);
      end
    end

    if (rd_en) begin
      rd_ptr_nxt = rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= key_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= dq_pkg::command_t'(in_command);
      key_r <= in_key;
    end
    rd_ptr_r     <= rd_ptr_nxt;
    remain_r     <= remain_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_key_out = out_key_r;
  assign out_last    = out_last_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("element count above capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && !full) |=> (count_r == $past(count_r) + 1'b1))
    else $error("accepted push did not grow the queue");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_init |-> !empty)
    else $error("dump walk started on empty queue");

  a_emit_remain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_elem |-> (remain_r != '0))
    else $error("element emitted past end of walk");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push || cmd.empty_result || cmd.emit_elem) |-> out_free)
    else $error("result loaded over a pending item");
`endif

endmodule

@@ rtl/dq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dq_ctrl
// Command sequencer: accept an item, execute a push or an empty dump, or
// step the dump walker one element per free output slot.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output dq_pkg::dp_cmd_t  cmd,
  input  dq_pkg::dp_stat_t stat
);

  dq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      dq_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = dq_pkg::S_EXEC;
        end
      end
      dq_pkg::S_EXEC: begin
        if (!stat.is_dump) begin
          if (stat.out_free) begin
            cmd.push  = 1'b1;
            state_nxt = dq_pkg::S_IDLE;
          end
        end else if (stat.empty) begin
          if (stat.out_free) begin
            cmd.empty_result = 1'b1;
            state_nxt        = dq_pkg::S_IDLE;
          end
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = dq_pkg::S_DUMP;
        end
      end
      dq_pkg::S_DUMP: begin
        if (stat.out_free) begin
          cmd.emit_elem = 1'b1;
          if (stat.walk_last) begin
            state_nxt = dq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = dq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/deque_push_and_dump_top.sv @@
// ----------------------------------------------------------------------------
// deque_push_and_dump_top
// Double-ended queue of signed keys in a ring store of CAPACITY entries.
// ----------------------------------------------------------------------------
// Commands: push front, push back, dump front to back, dump back to front.
// A push is latched on acceptance, then executed with one store write unless
// the queue is full, loading its status item. A dump of n keys is latched,
// issues the first read, then yields one item per cycle from the store's
// single registered read port while the output is taken. An empty dump is
// latched, then loads its status item. A held output register stalls the
// sequencer; the next item is accepted as soon as the last result is loaded.
// ----------------------------------------------------------------------------
module deque_push_and_dump_top #(
  parameter int CAPACITY  = dq_pkg::CAPACITY,
  parameter int KEY_WIDTH = dq_pkg::KEY_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_command,
  input  logic signed [KEY_WIDTH-1:0] in_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic signed [KEY_WIDTH-1:0] out_key_out,
  output logic                        out_last
);

  dq_pkg::dp_cmd_t  cmd;
  dq_pkg::dp_stat_t stat;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  dq_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_command  (in_command),
    .in_key      (in_key),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_key_out (out_key_out),
    .out_last    (out_last),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule
